FILE: hdl/mjm_pkg.sv
// Shared types and constants for the morphing Mandelbrot/Julia escape-time block.
// Used by the front stage, the iteration cells and the top level.
`default_nettype none

package mjm_pkg;

   // fixed field widths of the stream and register beats
   localparam int REG_W   = 18;
   localparam int COORD_W = 18;
   localparam int PIX_W   = 10;
   localparam int ITER_W  = 7;

   // register indexes on the csr port (byte address / 4)
   typedef enum logic [1:0] {
      REG_COS = 2'd0,
      REG_SIN = 2'd1,
      REG_JRE = 2'd2,
      REG_JIM = 2'd3
   } csr_reg_type;

   // control travelling with each pixel along the cell chain
   typedef struct packed {
      logic valid;
      logic done;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/mjm_init.sv
// Front stages: forms the start value z0 = p*cos and the constant c = J*cos + p*sin.
// Two register stages (products, then scale/sum/saturate). Depends on mjm_pkg.
`default_nettype none

module mjm_init #(
   parameter int FRAC_BITS = 16,
   localparam int Z_W = FRAC_BITS + 4,
   localparam int C_W = 37 - FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire logic                                req_valid,
   input  wire logic signed [mjm_pkg::COORD_W-1:0]  coord_re,
   input  wire logic signed [mjm_pkg::COORD_W-1:0]  coord_im,
   input  wire logic        [mjm_pkg::PIX_W-1:0]    pixel_x,
   input  wire logic        [mjm_pkg::PIX_W-1:0]    pixel_y,
   input  wire logic signed [mjm_pkg::REG_W-1:0]    cos_angle,
   input  wire logic signed [mjm_pkg::REG_W-1:0]    sin_angle,
   input  wire logic signed [mjm_pkg::REG_W-1:0]    julia_re,
   input  wire logic signed [mjm_pkg::REG_W-1:0]    julia_im,
   output mjm_pkg::cell_ctl_type                    dn_ctl,
   output logic signed [Z_W-1:0]                    dn_zx,
   output logic signed [Z_W-1:0]                    dn_zy,
   output logic signed [C_W-1:0]                    dn_cr,
   output logic signed [C_W-1:0]                    dn_ci,
   output logic        [mjm_pkg::PIX_W-1:0]         dn_x,
   output logic        [mjm_pkg::PIX_W-1:0]         dn_y
);

   localparam int P_W = 2 * mjm_pkg::REG_W;
   localparam logic signed [P_W-1:0] LIM_P  = P_W'(4) <<< FRAC_BITS;
   localparam logic signed [P_W-1:0] NLIM_P = -LIM_P;

   // stage A: raw products
   logic                              valid_a_ff;
   logic signed [P_W-1:0]             jrc_ff, prs_ff, jic_ff, pis_ff, prc_ff, pic_ff;
   logic        [mjm_pkg::PIX_W-1:0]  x_a_ff, y_a_ff;

   // stage B: scaled values
   mjm_pkg::cell_ctl_type             ctl_b_ff;
   logic signed [Z_W-1:0]             zx_b_ff, zy_b_ff;
   logic signed [C_W-1:0]             cr_b_ff, ci_b_ff;
   logic        [mjm_pkg::PIX_W-1:0]  x_b_ff, y_b_ff;

   logic signed [P_W:0]               cr_sum, ci_sum;
   logic signed [Z_W-1:0]             zx_in, zy_in;
   logic signed [C_W-1:0]             cr_in, ci_in;

   // saturate a scaled product to +/-4.0
   function automatic logic signed [Z_W-1:0] sat4(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] s;
      s = v;
      if (v > LIM_P) begin
         s = LIM_P;
      end else if (v < NLIM_P) begin
         s = NLIM_P;
      end
      return Z_W'(s);
   endfunction

   // scale (floor shift), sum and saturate
   always_comb begin
      cr_sum = (P_W+1)'(jrc_ff >>> FRAC_BITS) + (P_W+1)'(prs_ff >>> FRAC_BITS);
      ci_sum = (P_W+1)'(jic_ff >>> FRAC_BITS) + (P_W+1)'(pis_ff >>> FRAC_BITS);
      cr_in  = C_W'(cr_sum);
      ci_in  = C_W'(ci_sum);
      zx_in  = sat4(prc_ff >>> FRAC_BITS);
      zy_in  = sat4(pic_ff >>> FRAC_BITS);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         ctl_b_ff   <= '0;
      end else if (adv) begin
         valid_a_ff     <= req_valid;
         ctl_b_ff.valid <= valid_a_ff;
         ctl_b_ff.done  <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         jrc_ff  <= julia_re * cos_angle;
         prs_ff  <= coord_re * sin_angle;
         jic_ff  <= julia_im * cos_angle;
         pis_ff  <= coord_im * sin_angle;
         prc_ff  <= coord_re * cos_angle;
         pic_ff  <= coord_im * cos_angle;
         x_a_ff  <= pixel_x;
         y_a_ff  <= pixel_y;
         zx_b_ff <= zx_in;
         zy_b_ff <= zy_in;
         cr_b_ff <= cr_in;
         ci_b_ff <= ci_in;
         x_b_ff  <= x_a_ff;
         y_b_ff  <= y_a_ff;
      end
   end

   assign dn_ctl = ctl_b_ff;
   assign dn_zx  = zx_b_ff;
   assign dn_zy  = zy_b_ff;
   assign dn_cr  = cr_b_ff;
   assign dn_ci  = ci_b_ff;
   assign dn_x   = x_b_ff;
   assign dn_y   = y_b_ff;

endmodule

`default_nettype wire

FILE: hdl/mjm_cell.sv
// One iteration cell: does a single z := z^2 + c step and the escape test,
// then hands the pixel to the next cell. Depends on mjm_pkg.
`default_nettype none

module mjm_cell #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_ITER  = 64,
   localparam int Z_W   = FRAC_BITS + 4,
   localparam int C_W   = 37 - FRAC_BITS,
   localparam int CNT_W = $clog2(MAX_ITER + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire mjm_pkg::cell_ctl_type        up_ctl,
   input  wire logic signed [Z_W-1:0]        up_zx,
   input  wire logic signed [Z_W-1:0]        up_zy,
   input  wire logic signed [C_W-1:0]        up_cr,
   input  wire logic signed [C_W-1:0]        up_ci,
   input  wire logic        [CNT_W-1:0]      up_cnt,
   input  wire logic        [mjm_pkg::PIX_W-1:0] up_x,
   input  wire logic        [mjm_pkg::PIX_W-1:0] up_y,
   output mjm_pkg::cell_ctl_type             dn_ctl,
   output logic signed [Z_W-1:0]             dn_zx,
   output logic signed [Z_W-1:0]             dn_zy,
   output logic signed [C_W-1:0]             dn_cr,
   output logic signed [C_W-1:0]             dn_ci,
   output logic        [CNT_W-1:0]           dn_cnt,
   output logic        [mjm_pkg::PIX_W-1:0]  dn_x,
   output logic        [mjm_pkg::PIX_W-1:0]  dn_y
);

   localparam int SUM_W = (FRAC_BITS + 8 > 39 - FRAC_BITS) ? FRAC_BITS + 8 : 39 - FRAC_BITS;
   localparam logic signed [SUM_W-1:0] LIM_S  = SUM_W'(4) <<< FRAC_BITS;
   localparam logic signed [SUM_W-1:0] NLIM_S = -LIM_S;

   mjm_pkg::cell_ctl_type             ctl_ff, ctl_in;
   logic signed [Z_W-1:0]             zx_ff, zy_ff, zx_in, zy_in;
   logic signed [C_W-1:0]             cr_ff, ci_ff;
   logic        [CNT_W-1:0]           cnt_ff, cnt_in, cnt_inc;
   logic        [mjm_pkg::PIX_W-1:0]  x_ff, y_ff;

   logic signed [Z_W:0]               zx_dbl;
   logic signed [2*Z_W-1:0]           sq_x, sq_y;
   logic signed [2*Z_W:0]             prod_xy;
   logic signed [SUM_W-1:0]           zx2, zy2, xy2, nzx, nzy, mag;
   logic                              esc;

   // saturate to +/-4.0
   function automatic logic signed [Z_W-1:0] sat4(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] s;
      s = v;
      if (v > LIM_S) begin
         s = LIM_S;
      end else if (v < NLIM_S) begin
         s = NLIM_S;
      end
      return Z_W'(s);
   endfunction

   // squares and cross term, scaled by a floor shift
   always_comb begin
      zx_dbl  = $signed({up_zx, 1'b0});
      sq_x    = up_zx * up_zx;
      sq_y    = up_zy * up_zy;
      prod_xy = zx_dbl * up_zy;
      zx2     = SUM_W'(sq_x >>> FRAC_BITS);
      zy2     = SUM_W'(sq_y >>> FRAC_BITS);
      xy2     = SUM_W'(prod_xy >>> FRAC_BITS);
      nzx     = zx2 - zy2 + SUM_W'(up_cr);
      nzy     = xy2 + SUM_W'(up_ci);
      mag     = zx2 + zy2;
      esc     = (mag >= LIM_S);
      zx_in   = sat4(nzx);
      zy_in   = sat4(nzy);
   end

   // count and finish flag; a finished pixel keeps its count and stays finished
   always_comb begin
      cnt_inc      = up_cnt + CNT_W'(1);
      ctl_in.valid = up_ctl.valid;
      if (up_ctl.done) begin
         cnt_in      = up_cnt;
         ctl_in.done = 1'b1;
      end else begin
         cnt_in      = cnt_inc;
         ctl_in.done = esc || (cnt_inc == CNT_W'(MAX_ITER));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zx_ff  <= zx_in;
         zy_ff  <= zy_in;
         cr_ff  <= up_cr;
         ci_ff  <= up_ci;
         cnt_ff <= cnt_in;
         x_ff   <= up_x;
         y_ff   <= up_y;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_zx  = zx_ff;
   assign dn_zy  = zy_ff;
   assign dn_cr  = cr_ff;
   assign dn_ci  = ci_ff;
   assign dn_cnt = cnt_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;

endmodule

`default_nettype wire

FILE: hdl/mandel_julia_morph_escape_time.sv
// Path: an accepted req beat passes the two front stages, one cell per iteration
// and one output register on its way to its rsp beat.
// Throughput: one pixel per cycle when not stalled; each cell does one iteration step.
// The chain advances as a whole; it stops only while a full output register is stalled.
// Reset (synchronous, active high) empties the chain and output and loads the
// csr registers with cos 1.0, sin 0, Julia constant 0 + 1.0i.
`default_nettype none

module mandel_julia_morph_escape_time #(
   parameter int MAX_ITER  = 64,
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // coord_re[17:0], coord_im[35:18], pixel_x[45:36], pixel_y[55:46]
   input  wire logic [55:0] req_tdata,
   // stream out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_x[9:0], out_y[19:10], iter_count[26:20], zero[31:27]
   output logic [31:0]      rsp_tdata,
   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int Z_W   = FRAC_BITS + 4;
   localparam int C_W   = 37 - FRAC_BITS;
   localparam int CNT_W = $clog2(MAX_ITER + 1);
   localparam int RW    = mjm_pkg::REG_W;
   localparam int PW    = mjm_pkg::PIX_W;

   // csr registers
   logic signed [RW-1:0] cos_ff, sin_ff, jre_ff, jim_ff;
   logic signed [RW-1:0] cos_in, sin_in, jre_in, jim_in;
   logic                 csr_wr;
   mjm_pkg::csr_reg_type csr_sel;

   // cell chain; entry i feeds cell i
   mjm_pkg::cell_ctl_type      ctl_s [MAX_ITER+1];
   logic signed [Z_W-1:0]      zx_s  [MAX_ITER+1];
   logic signed [Z_W-1:0]      zy_s  [MAX_ITER+1];
   logic signed [C_W-1:0]      cr_s  [MAX_ITER+1];
   logic signed [C_W-1:0]      ci_s  [MAX_ITER+1];
   logic        [CNT_W-1:0]    cnt_s [MAX_ITER+1];
   logic        [PW-1:0]       x_s   [MAX_ITER+1];
   logic        [PW-1:0]       y_s   [MAX_ITER+1];

   // output register
   logic                          out_v_ff, out_v_in;
   logic [PW-1:0]                 out_x_ff, out_y_ff;
   logic [mjm_pkg::ITER_W-1:0]    out_cnt_ff;
   logic                          out_free, adv, last_v;

   // csr decode and write
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = mjm_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      cos_in = cos_ff;
      sin_in = sin_ff;
      jre_in = jre_ff;
      jim_in = jim_ff;
      if (csr_wr) begin
         case (csr_sel)
            mjm_pkg::REG_COS: cos_in = csr_pwdata[RW-1:0];
            mjm_pkg::REG_SIN: sin_in = csr_pwdata[RW-1:0];
            mjm_pkg::REG_JRE: jre_in = csr_pwdata[RW-1:0];
            mjm_pkg::REG_JIM: jim_in = csr_pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= 18'sd65536;
         sin_ff <= 18'sd0;
         jre_ff <= 18'sd0;
         jim_ff <= 18'sd65536;
      end else begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         jre_ff <= jre_in;
         jim_ff <= jim_in;
      end
   end

   // readback, sign-extended
   always_comb begin
      case (csr_sel)
         mjm_pkg::REG_COS: csr_prdata = 32'(cos_ff);
         mjm_pkg::REG_SIN: csr_prdata = 32'(sin_ff);
         mjm_pkg::REG_JRE: csr_prdata = 32'(jre_ff);
         mjm_pkg::REG_JIM: csr_prdata = 32'(jim_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // flow control: the chain moves unless its last beat is blocked by a stalled output
   assign last_v     = ctl_s[MAX_ITER].valid;
   assign out_free   = !out_v_ff || rsp_tready;
   assign adv        = out_free || !last_v;
   assign req_tready = adv;

   // front stages
   mjm_init #(
      .FRAC_BITS(FRAC_BITS)
   ) u_init (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_tvalid),
      .coord_re  (req_tdata[17:0]),
      .coord_im  (req_tdata[35:18]),
      .pixel_x   (req_tdata[45:36]),
      .pixel_y   (req_tdata[55:46]),
      .cos_angle (cos_ff),
      .sin_angle (sin_ff),
      .julia_re  (jre_ff),
      .julia_im  (jim_ff),
      .dn_ctl    (ctl_s[0]),
      .dn_zx     (zx_s[0]),
      .dn_zy     (zy_s[0]),
      .dn_cr     (cr_s[0]),
      .dn_ci     (ci_s[0]),
      .dn_x      (x_s[0]),
      .dn_y      (y_s[0])
   );

   assign cnt_s[0] = '0;

   // one cell per iteration
   for (genvar i = 0; i < MAX_ITER; i++) begin : g_cell
      mjm_cell #(
         .FRAC_BITS(FRAC_BITS),
         .MAX_ITER (MAX_ITER)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .up_ctl (ctl_s[i]),
         .up_zx  (zx_s[i]),
         .up_zy  (zy_s[i]),
         .up_cr  (cr_s[i]),
         .up_ci  (ci_s[i]),
         .up_cnt (cnt_s[i]),
         .up_x   (x_s[i]),
         .up_y   (y_s[i]),
         .dn_ctl (ctl_s[i+1]),
         .dn_zx  (zx_s[i+1]),
         .dn_zy  (zy_s[i+1]),
         .dn_cr  (cr_s[i+1]),
         .dn_ci  (ci_s[i+1]),
         .dn_cnt (cnt_s[i+1]),
         .dn_x   (x_s[i+1]),
         .dn_y   (y_s[i+1])
      );
   end

   // output register
   always_comb begin
      out_v_in = out_v_ff;
      if (adv && last_v) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_v) begin
         out_x_ff   <= x_s[MAX_ITER];
         out_y_ff   <= y_s[MAX_ITER];
         out_cnt_ff <= mjm_pkg::ITER_W'(cnt_s[MAX_ITER]);
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'b0, out_cnt_ff, out_y_ff, out_x_ff};

endmodule

`default_nettype wire

FILE: hdl/mjm_chk.sv
// Port-level checks for the escape-time block, bound to its top level.
// Depends only on the top level's ports and its MAX_ITER parameter.
`default_nettype none

module mjm_chk #(
   parameter int MAX_ITER = 64
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [3:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // with no result waiting the input side is open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req not ready with empty output");

   // iteration count is never zero while it fits the field
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (MAX_ITER >= 128) || (rsp_tdata[26:20] != 7'd0))
      else $error("zero iteration count");

   // a written register reads back sign-extended
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(csr_psel && csr_penable && csr_pwrite)
      && csr_psel && !csr_pwrite && (csr_paddr[3:2] == $past(csr_paddr[3:2]))
      |-> (csr_prdata[17:0] == $past(csr_pwdata[17:0]))
          && (csr_prdata[31:18] == {14{csr_prdata[17]}}))
      else $error("csr readback mismatch");

endmodule

bind mandel_julia_morph_escape_time mjm_chk #(
   .MAX_ITER(MAX_ITER)
) u_mjm_chk (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire
